@@ rtl/core/hid_mouse_motion_smoother_top_assert.svh @@
// assertion macros for the mouse motion smoother checker
// included by hmms_checker.sv; needs nothing else
`ifndef HID_MOUSE_MOTION_SMOOTHER_TOP_ASSERT_SVH
`define HID_MOUSE_MOTION_SMOOTHER_TOP_ASSERT_SVH

// condition now implies property now
`define HMMS_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("hmms same-cycle check failed");

// condition now implies property in the next cycle
`define HMMS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("hmms next-cycle check failed");

// property holds in the cycle after reset
`define HMMS_ASSERT_AFTER_RESET(label, clk, rst, post) \
   label: assert property (@(posedge clk) (rst) |=> (post)) \
      else $error("hmms post-reset check failed");

`endif

@@ rtl/core/hmms_pkg.sv @@
// shared types, constants and helpers for the mouse motion smoother
// no dependencies
package hmms_pkg;

   localparam int TICK_MS_DEFAULT      = 20;
   localparam int BUTTON_COUNT_DEFAULT = 3;

   localparam int AXIS_COUNT = 3;
   localparam int AXIS_W     = 32;
   localparam int DELTA_W    = 16;
   localparam int DUR_W      = 16;
   localparam int MASK_W     = 3;
   localparam int EVENT_W    = 2;
   localparam int KIND_W     = 2;
   localparam int STEP_W     = 8;
   localparam int PHASE_W    = 8;
   localparam int QUO_W      = 7;
   localparam int QBIT_W     = $clog2(QUO_W);
   localparam int REM_W      = DUR_W + QUO_W;

   localparam logic [STEP_W-1:0] RATE_MAX = 8'd127;

   // input tdata layout
   localparam int DX_LSB    = 0;
   localparam int DY_LSB    = DX_LSB + DELTA_W;
   localparam int DUR_LSB   = DY_LSB + DELTA_W;
   localparam int MASK_LSB  = DUR_LSB + DUR_W;
   localparam int EVENT_LSB = MASK_LSB + MASK_W;
   localparam int REQ_USED_W   = EVENT_LSB + EVENT_W;
   localparam int REQ_TDATA_W  = ((REQ_USED_W + 7) / 8) * 8;

   // result tdata layout
   localparam int RSP_USED_W   = MASK_W + 3 * STEP_W;
   localparam int RSP_TDATA_W  = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_USED_W;

   localparam logic [1:0] AXIS_X     = 2'd0;
   localparam logic [1:0] AXIS_Y     = 2'd1;
   localparam logic [1:0] AXIS_WHEEL = 2'd2;

   // button phase codes and timings
   localparam logic [PHASE_W-1:0] PH_OFF         = 8'd0;
   localparam logic [PHASE_W-1:0] PH_HELD        = 8'hff;
   localparam logic [PHASE_W-1:0] PH_CLICK_START = 8'd1;
   localparam logic [PHASE_W-1:0] PH_DBL_START   = 8'd50;
   localparam int CLICK_MS        = 100;
   localparam int DBL_GAP_MS      = 100;
   localparam int DBL_GAP_DONE_MS = 250;
   localparam int DBL_DONE_MS     = 350;

   typedef enum logic [KIND_W-1:0] {
      REQ_TICK    = 2'd0,
      REQ_MOVE    = 2'd1,
      REQ_WHEEL   = 2'd2,
      REQ_BUTTONS = 2'd3
   } req_kind_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_UP     = 2'd0,
      EV_DOWN   = 2'd1,
      EV_CLICK  = 2'd2,
      EV_DOUBLE = 2'd3
   } btn_event_type;

   typedef struct packed {
      logic capture;
      logic tick;
      logic set_buttons;
      logic add;
      logic mul;
      logic check;
      logic div;
      logic rate;
   } hmms_cmd_type;

   typedef struct packed {
      logic out_busy;
      logic div_last;
      logic more_axes;
   } hmms_status_type;

   function automatic logic [PHASE_W-1:0] event_phase(input btn_event_type ev);
      logic [PHASE_W-1:0] ph;
      unique case (ev)
         EV_UP:     ph = PH_OFF;
         EV_DOWN:   ph = PH_HELD;
         EV_CLICK:  ph = PH_CLICK_START;
         EV_DOUBLE: ph = PH_DBL_START;
      endcase
      return ph;
   endfunction

endpackage

@@ rtl/core/hid_mouse_motion_smoother_top.sv @@
// top level of the mouse motion smoother: controller plus datapath
// depends on hmms_pkg, hmms_ctrl, hmms_datapath
//
// channel  dir  tdata (low bit up)                                   tuser
// req_     in   delta_x[15:0] delta_y[31:16] duration[47:32]         req_type[1:0]
//               button_mask[50:48] button_event[52:51] zero[55:53]
// rsp_     out  pressed_buttons[2:0] move_x[10:3] move_y[18:11]      -
//               wheel_step[26:19] zero[31:27]
//
// one item at a time: requests are taken only in the idle state; a move loads x then y
// axis loads are set by the 7-step restoring divider
// a tick waits only while a previous result is still held by rsp_tready low
// synchronous reset clears targets, rates, button phases and the result slot
module hid_mouse_motion_smoother_top
   import hmms_pkg::*;
#(
   parameter int TICK_MS      = TICK_MS_DEFAULT,
   parameter int BUTTON_COUNT = BUTTON_COUNT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // delta_x, delta_y, duration, button_mask, button_event
   input  logic [KIND_W-1:0]      req_tuser,  // req_type
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // pressed_buttons, move_x, move_y, wheel_step
);

   hmms_cmd_type    cmd;
   hmms_status_type status;

   hmms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status)
   );

   hmms_datapath #(
      .TICK_MS      (TICK_MS),
      .BUTTON_COUNT (BUTTON_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ rtl/core/hmms_datapath.sv @@
// datapath: axis targets and rates, shared restoring divider, button phases,
// result register; depends on hmms_pkg
module hmms_datapath
   import hmms_pkg::*;
#(
   parameter int TICK_MS      = TICK_MS_DEFAULT,
   parameter int BUTTON_COUNT = BUTTON_COUNT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [KIND_W-1:0]      req_tuser,
   input  hmms_cmd_type           cmd,
   output hmms_status_type        status,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int TICK_W   = $clog2(TICK_MS + 1);
   localparam int PROD_W   = AXIS_W + TICK_W;
   localparam int BTN_USED = (BUTTON_COUNT < MASK_W) ? BUTTON_COUNT : MASK_W;
   localparam logic [TICK_W-1:0] TICK_LIT = TICK_W'(TICK_MS);

   localparam int PH_CLICK_DONE   = int'(PH_CLICK_START) + CLICK_MS / TICK_MS;
   localparam int PH_DBL_GAP      = int'(PH_DBL_START) + DBL_GAP_MS / TICK_MS;
   localparam int PH_DBL_GAP_DONE = int'(PH_DBL_START) + DBL_GAP_DONE_MS / TICK_MS;
   localparam int PH_DBL_DONE     = int'(PH_DBL_START) + DBL_DONE_MS / TICK_MS;

   // architectural state
   logic signed [AXIS_W-1:0] target_ff [AXIS_COUNT];
   logic signed [STEP_W-1:0] rate_ff   [AXIS_COUNT];
   logic [PHASE_W-1:0]       phase_ff  [BTN_USED];
   logic                     prior_zero_ff;
   logic                     rsp_valid_ff;
   logic [1:0]               axis_ff;
   logic [QBIT_W-1:0]        bit_ff;

   // captured command and divider payload
   req_kind_type             kind_ff;
   logic signed [DELTA_W-1:0] dx_ff;
   logic signed [DELTA_W-1:0] dy_ff;
   logic [DUR_W-1:0]         dur_ff;
   logic [MASK_W-1:0]        mask_ff;
   btn_event_type            event_ff;
   logic [PROD_W-1:0]        mag_ff;
   logic [QUO_W-1:0]         quo_ff;
   logic                     neg_ff;
   logic                     sat_ff;
   logic [RSP_TDATA_W-1:0]   rsp_data_ff;

   logic [DUR_W-1:0]         ms;
   logic signed [DELTA_W-1:0] delta;
   logic signed [AXIS_W-1:0] cur_target;
   logic [AXIS_W-1:0]        cur_abs;
   logic [REM_W-1:0]         rem;
   logic [REM_W-1:0]         trial;
   logic [STEP_W-1:0]        rate_mag;
   logic signed [STEP_W-1:0] rate_in;

   logic signed [STEP_W-1:0] step      [AXIS_COUNT];
   logic signed [AXIS_W-1:0] target_in [AXIS_COUNT];
   logic [PHASE_W-1:0]       phase_in  [BTN_USED];
   logic [MASK_W-1:0]        pressed;
   logic                     report_zero;
   logic                     emit;

   always_comb begin
      ms         = (dur_ff == '0) ? DUR_W'(1) : dur_ff;
      delta      = (axis_ff == AXIS_X) ? dx_ff : dy_ff;
      cur_target = target_ff[axis_ff];
      cur_abs    = cur_target[AXIS_W-1] ? (~cur_target + AXIS_W'(1)) : cur_target;
      rem        = mag_ff[REM_W-1:0];
      trial      = REM_W'(ms) << bit_ff;
      rate_mag   = sat_ff ? RATE_MAX : {1'b0, quo_ff};
      rate_in    = neg_ff ? -rate_mag : rate_mag;
   end

   // per-tick axis steps, no overshoot
   always_comb begin
      logic [AXIS_W-1:0] t_abs;
      logic [STEP_W-1:0] s_abs;
      for (int a = 0; a < AXIS_COUNT; a++) begin
         t_abs = target_ff[a][AXIS_W-1] ? (~target_ff[a] + AXIS_W'(1)) : target_ff[a];
         s_abs = rate_ff[a][STEP_W-1] ? (~rate_ff[a] + STEP_W'(1)) : rate_ff[a];
         step[a] = (t_abs < AXIS_W'(s_abs)) ? target_ff[a][STEP_W-1:0] : rate_ff[a];
         target_in[a] = target_ff[a] - {{(AXIS_W-STEP_W){step[a][STEP_W-1]}}, step[a]};
      end
   end

   // button report and phase advance
   always_comb begin
      int p;
      pressed = '0;
      for (int i = 0; i < BTN_USED; i++) begin
         p = int'(phase_ff[i]);
         pressed[i] = (phase_ff[i] != PH_OFF) && !(p >= PH_DBL_GAP && p < PH_DBL_GAP_DONE);
         if (phase_ff[i] == PH_OFF || p == PH_CLICK_DONE || p == PH_DBL_DONE) begin
            phase_in[i] = PH_OFF;
         end else if (phase_ff[i] == PH_HELD) begin
            phase_in[i] = PH_HELD;
         end else begin
            phase_in[i] = phase_ff[i] + PHASE_W'(1);
         end
      end
      report_zero = (pressed == '0) && (step[0] == '0) && (step[1] == '0) && (step[2] == '0);
      emit = !(report_zero && prior_zero_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXIS_COUNT; a++) begin
            target_ff[a] <= '0;
            rate_ff[a]   <= '0;
         end
         for (int i = 0; i < BTN_USED; i++) begin
            phase_ff[i] <= PH_OFF;
         end
         prior_zero_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         axis_ff       <= AXIS_X;
         bit_ff        <= '0;
      end else begin
         if (cmd.tick && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.capture) begin
            axis_ff <= (req_kind_type'(req_tuser) == REQ_WHEEL) ? AXIS_WHEEL : AXIS_X;
         end
         if (cmd.tick) begin
            for (int a = 0; a < AXIS_COUNT; a++) begin
               target_ff[a] <= target_in[a];
            end
            for (int i = 0; i < BTN_USED; i++) begin
               phase_ff[i] <= phase_in[i];
            end
            if (emit) begin
               prior_zero_ff <= report_zero;
            end
         end
         if (cmd.set_buttons) begin
            for (int i = 0; i < BTN_USED; i++) begin
               if (mask_ff[i]) begin
                  phase_ff[i] <= event_phase(event_ff);
               end
            end
         end
         if (cmd.add) begin
            target_ff[axis_ff] <= cur_target + {{(AXIS_W-DELTA_W){delta[DELTA_W-1]}}, delta};
         end
         if (cmd.check) begin
            bit_ff <= QBIT_W'(QUO_W - 1);
         end
         if (cmd.div) begin
            bit_ff <= bit_ff - QBIT_W'(1);
         end
         if (cmd.rate) begin
            rate_ff[axis_ff] <= rate_in;
            if (status.more_axes) begin
               axis_ff <= AXIS_Y;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind_type'(req_tuser);
         dx_ff    <= req_tdata[DX_LSB +: DELTA_W];
         dy_ff    <= req_tdata[DY_LSB +: DELTA_W];
         dur_ff   <= req_tdata[DUR_LSB +: DUR_W];
         mask_ff  <= req_tdata[MASK_LSB +: MASK_W];
         event_ff <= btn_event_type'(req_tdata[EVENT_LSB +: EVENT_W]);
      end
      if (cmd.mul) begin
         neg_ff <= cur_target[AXIS_W-1];
         mag_ff <= {{TICK_W{1'b0}}, cur_abs} * {{AXIS_W{1'b0}}, TICK_LIT};
      end
      if (cmd.check) begin
         sat_ff <= mag_ff >= PROD_W'({ms, {QUO_W{1'b0}}});
         quo_ff <= '0;
      end
      if (cmd.div && (rem >= trial)) begin
         mag_ff <= PROD_W'(rem - trial);
         quo_ff[bit_ff] <= 1'b1;
      end
      if (cmd.tick && emit) begin
         rsp_data_ff <= {{RSP_PAD_W{1'b0}}, step[2], step[1], step[0], pressed};
      end
   end

   assign status.out_busy  = rsp_valid_ff && !rsp_tready;
   assign status.div_last  = (bit_ff == '0);
   assign status.more_axes = (kind_ff == REQ_MOVE) && (axis_ff == AXIS_X);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ rtl/core/hmms_ctrl.sv @@
// controller state machine sequencing ticks, button loads and axis rate loads
// depends on hmms_pkg
module hmms_ctrl
   import hmms_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [KIND_W-1:0] req_tuser,
   output hmms_cmd_type    cmd,
   input  hmms_status_type status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_TICK,
      S_BTN,
      S_ADD,
      S_MUL,
      S_CHECK,
      S_DIV,
      S_RATE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               unique case (req_kind_type'(req_tuser))
                  REQ_TICK:              state_in = S_TICK;
                  REQ_MOVE, REQ_WHEEL:   state_in = S_ADD;
                  REQ_BUTTONS:           state_in = S_BTN;
               endcase
            end
         end
         S_TICK: begin
            if (!status.out_busy) begin
               cmd.tick = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_BTN: begin
            cmd.set_buttons = 1'b1;
            state_in        = S_IDLE;
         end
         S_ADD: begin
            cmd.add  = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            cmd.div = 1'b1;
            if (status.div_last) begin
               state_in = S_RATE;
            end
         end
         S_RATE: begin
            cmd.rate = 1'b1;
            state_in = status.more_axes ? S_ADD : S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/hmms_checker.sv @@
// port-level checks on the mouse motion smoother, bound to the top level
// depends on hmms_pkg and hid_mouse_motion_smoother_top_assert.svh
`include "hid_mouse_motion_smoother_top_assert.svh"

module hmms_checker
   import hmms_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   `HMMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `HMMS_ASSERT_NOW(a_rsp_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[31:27] == 5'd0)
   `HMMS_ASSERT_NOW(a_rsp_step_range, clock, reset, rsp_tvalid, (rsp_tdata[10:3] != 8'h80) && (rsp_tdata[18:11] != 8'h80) && (rsp_tdata[26:19] != 8'h80))
   `HMMS_ASSERT_AFTER_RESET(a_reset_state, clock, reset, !rsp_tvalid && req_tready)

endmodule

bind hid_mouse_motion_smoother_top hmms_checker u_hmms_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ dv/hid_mouse_motion_smoother_top_tb.sv @@
// self-checking testbench for hid_mouse_motion_smoother_top
// a scoreboard class predicts each tick report from the accepted commands
// depends on hmms_pkg and the rtl of hid_mouse_motion_smoother_top
`timescale 1ns / 1ps

module hid_mouse_motion_smoother_top_tb;
   import hmms_pkg::*;

   localparam int  RANDOM_ITEMS = 1250;
   localparam int  STALL_LIMIT  = 4000;
   localparam int  HOLD_CYCLES  = 600;
   localparam int  DRAIN_CYCLES = 64;
   localparam longint TICK      = TICK_MS_DEFAULT;

   // button phase landmarks at the default tick period
   localparam logic [PHASE_W-1:0] CLICK_END = PH_CLICK_START + CLICK_MS / TICK_MS_DEFAULT;
   localparam logic [PHASE_W-1:0] GAP_START = PH_DBL_START + DBL_GAP_MS / TICK_MS_DEFAULT;
   localparam logic [PHASE_W-1:0] GAP_END   = PH_DBL_START + DBL_GAP_DONE_MS / TICK_MS_DEFAULT;
   localparam logic [PHASE_W-1:0] DBL_END   = PH_DBL_START + DBL_DONE_MS / TICK_MS_DEFAULT;

   typedef struct packed {
      logic [MASK_W-1:0]        buttons;
      logic signed [STEP_W-1:0] step_x;
      logic signed [STEP_W-1:0] step_y;
      logic signed [STEP_W-1:0] step_wheel;
   } motion_report_type;

   class report_scoreboard;
      logic signed [AXIS_W-1:0] remaining [AXIS_COUNT];
      logic signed [STEP_W-1:0] pace [AXIS_COUNT];
      logic [PHASE_W-1:0]       btn_state [MASK_W];
      bit                       quiet;
      motion_report_type        pending_reports [$];
      int                       errors;

      function new();
         for (int a = 0; a < AXIS_COUNT; a++) begin
            remaining[a] = '0;
            pace[a] = '0;
         end
         for (int b = 0; b < MASK_W; b++) btn_state[b] = PH_OFF;
         quiet = 1'b0;
         errors = 0;
      endfunction

      function void retarget_axis(int a, logic signed [DELTA_W-1:0] delta,
                                  logic [DUR_W-1:0] dur);
         longint ms;
         longint q;
         remaining[a] = remaining[a] + 32'(delta);
         ms = (dur == '0) ? 64'sd1 : longint'(dur);
         q = (TICK * longint'(remaining[a])) / ms;
         if (q > 127) q = 127;
         else if (q < -127) q = -127;
         pace[a] = q[STEP_W-1:0];
      endfunction

      function logic signed [STEP_W-1:0] advance_axis(int a);
         logic signed [AXIS_W-1:0] t;
         logic signed [STEP_W-1:0] s;
         longint mag_t;
         longint mag_s;
         t = remaining[a];
         s = pace[a];
         mag_t = (t < 0) ? -longint'(t) : longint'(t);
         mag_s = (s < 0) ? -longint'(s) : longint'(s);
         if (mag_t < mag_s) s = t[STEP_W-1:0];
         remaining[a] = t - 32'(s);
         return s;
      endfunction

      function void note_command(logic [KIND_W-1:0] kind, logic [REQ_TDATA_W-1:0] data);
         logic signed [DELTA_W-1:0] dx;
         logic signed [DELTA_W-1:0] dy;
         logic [DUR_W-1:0]          dur;
         logic [MASK_W-1:0]         mask;
         logic [PHASE_W-1:0]        load;
         logic [PHASE_W-1:0]        p;
         motion_report_type         rep;
         bit                        zero;
         dx   = data[DX_LSB +: DELTA_W];
         dy   = data[DY_LSB +: DELTA_W];
         dur  = data[DUR_LSB +: DUR_W];
         mask = data[MASK_LSB +: MASK_W];
         case (req_kind_type'(kind))
            REQ_MOVE: begin
               retarget_axis(AXIS_X, dx, dur);
               retarget_axis(AXIS_Y, dy, dur);
            end
            REQ_WHEEL: begin
               retarget_axis(AXIS_WHEEL, dy, dur);
            end
            REQ_BUTTONS: begin
               case (btn_event_type'(data[EVENT_LSB +: EVENT_W]))
                  EV_UP:    load = PH_OFF;
                  EV_DOWN:  load = PH_HELD;
                  EV_CLICK: load = PH_CLICK_START;
                  default:  load = PH_DBL_START;
               endcase
               for (int b = 0; b < MASK_W; b++)
                  if (mask[b]) btn_state[b] = load;
            end
            default: begin
               rep.buttons = '0;
               for (int b = 0; b < MASK_W; b++) begin
                  p = btn_state[b];
                  // pressed unless off or in the double-click release pause
                  rep.buttons[b] = (p != PH_OFF) && !(p >= GAP_START && p < GAP_END);
                  if (p == CLICK_END || p == DBL_END || p == PH_OFF) btn_state[b] = PH_OFF;
                  else if (p != PH_HELD) btn_state[b] = p + 8'd1;
               end
               rep.step_x     = advance_axis(AXIS_X);
               rep.step_y     = advance_axis(AXIS_Y);
               rep.step_wheel = advance_axis(AXIS_WHEEL);
               zero = (rep == '0);
               if (!(zero && quiet)) begin
                  quiet = zero;
                  pending_reports.push_back(rep);
               end
            end
         endcase
      endfunction

      function void check_report(logic [RSP_TDATA_W-1:0] d);
         motion_report_type want;
         motion_report_type got;
         got.buttons    = d[0 +: MASK_W];
         got.step_x     = d[MASK_W +: STEP_W];
         got.step_y     = d[MASK_W + STEP_W +: STEP_W];
         got.step_wheel = d[MASK_W + 2 * STEP_W +: STEP_W];
         if (pending_reports.size() == 0) begin
            $error("unexpected report transfer: tdata %h", d);
            errors++;
         end else begin
            want = pending_reports.pop_front();
            if (got.buttons != want.buttons) begin
               $error("pressed_buttons: expected %0d, got %0d", want.buttons, got.buttons);
               errors++;
            end
            if (got.step_x != want.step_x) begin
               $error("move_x: expected %0d, got %0d", want.step_x, got.step_x);
               errors++;
            end
            if (got.step_y != want.step_y) begin
               $error("move_y: expected %0d, got %0d", want.step_y, got.step_y);
               errors++;
            end
            if (got.step_wheel != want.step_wheel) begin
               $error("wheel_step: expected %0d, got %0d", want.step_wheel, got.step_wheel);
               errors++;
            end
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;  // delta_x, delta_y, duration, button_mask, button_event
   logic [KIND_W-1:0]      req_tuser;  // req_type
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // pressed_buttons, move_x, move_y, wheel_step

   report_scoreboard sb;
   int               idle_cycles = 0;

   hid_mouse_motion_smoother_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // transfer monitor and stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_command(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_report(rsp_tdata);
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("hid_mouse_motion_smoother_top: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: segments of differing stall patterns, one long hold-off
   initial begin
      int seg;
      int len;
      int mode;
      rsp_tready <= 1'b0;
      seg = 0;
      forever begin
         seg++;
         if (seg == 12) begin
            @(posedge clock);
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(10, 120);
            for (int c = 0; c < len; c++) begin
               @(posedge clock);
               case (mode)
                  0:       rsp_tready <= 1'b1;
                  1:       rsp_tready <= 1'($urandom_range(0, 1));
                  2:       rsp_tready <= (c % 4 == 0);
                  default: rsp_tready <= ($urandom_range(0, 9) > 6);
               endcase
            end
         end
      end
   end

   task automatic offer(req_kind_type kind, logic [DELTA_W-1:0] dx, logic [DELTA_W-1:0] dy,
                        logic [DUR_W-1:0] dur, logic [MASK_W-1:0] mask,
                        btn_event_type ev);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_TDATA_W'({ev, mask, dur, dy, dx});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic pause_sender(int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_for_reports();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_reports.size() != 0) @(posedge clock);
   endtask

   function automatic logic [DELTA_W-1:0] pick_delta();
      logic [DELTA_W-1:0] v;
      case ($urandom_range(0, 9))
         0:       v = DELTA_W'($urandom_range(0, 16'hffff));
         1: begin
            case ($urandom_range(0, 3))
               0:       v = 16'h8000;
               1:       v = 16'h7fff;
               2:       v = 16'hffff;
               default: v = 16'h0001;
            endcase
         end
         default: v = DELTA_W'($urandom_range(0, 400)) - 16'd200;
      endcase
      return v;
   endfunction

   function automatic logic [DUR_W-1:0] pick_duration();
      logic [DUR_W-1:0] v;
      case ($urandom_range(0, 9))
         0:       v = '0;
         1:       v = DUR_W'($urandom_range(0, 16'hffff));
         2:       v = 16'hffff;
         default: v = DUR_W'($urandom_range(1, 300));
      endcase
      return v;
   endfunction

   initial begin
      int sent;
      int burst;
      int r;
      req_kind_type kind;
      sb = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= REQ_TICK;
      req_tdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // first all-zero report goes out, the second is suppressed
      offer(REQ_TICK, '0, '0, '0, '0, EV_UP);
      offer(REQ_TICK, 16'hffff, 16'hffff, 16'hffff, 3'b111, EV_DOUBLE);
      // extreme deltas with zero duration saturate the rates
      offer(REQ_MOVE, 16'h7fff, 16'h8000, 16'd0, 3'b111, EV_DOUBLE);
      offer(REQ_TICK, '0, '0, '0, '0, EV_UP);
      offer(REQ_TICK, '0, '0, '0, '0, EV_UP);
      offer(REQ_WHEEL, 16'h8000, 16'h7fff, 16'hffff, '0, EV_UP);
      offer(REQ_TICK, '0, '0, '0, '0, EV_UP);
      offer(REQ_BUTTONS, '0, '0, '0, 3'b111, EV_DOWN);
      offer(REQ_TICK, '0, '0, '0, '0, EV_UP);
      offer(REQ_BUTTONS, '0, '0, '0, 3'b001, EV_CLICK);
      offer(REQ_BUTTONS, '0, '0, '0, 3'b010, EV_DOUBLE);
      offer(REQ_BUTTONS, '0, '0, '0, 3'b100, EV_UP);
      repeat (8) offer(REQ_TICK, '0, '0, '0, '0, EV_UP);
      offer(REQ_BUTTONS, '0, '0, '0, 3'b000, EV_DOWN);
      offer(REQ_MOVE, 16'h8001, 16'h7fff, 16'd1, '0, EV_UP);
      repeat (3) offer(REQ_TICK, '0, '0, '0, '0, EV_UP);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55) kind = REQ_TICK;
            else if (r < 70) kind = REQ_MOVE;
            else if (r < 80) kind = REQ_WHEEL;
            else kind = REQ_BUTTONS;
            offer(kind, pick_delta(), pick_delta(), pick_duration(),
                  MASK_W'($urandom_range(0, 7)), btn_event_type'($urandom_range(0, 3)));
            sent++;
            if (sent == RANDOM_ITEMS / 2) wait_for_reports();
         end
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 40));
      end

      wait_for_reports();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("hid_mouse_motion_smoother_top: match");
      end else begin
         $display("hid_mouse_motion_smoother_top: mismatch");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/hmms_pkg.sv
rtl/core/hmms_datapath.sv
rtl/core/hmms_ctrl.sv
rtl/core/hid_mouse_motion_smoother_top.sv
rtl/core/hmms_checker.sv
dv/hid_mouse_motion_smoother_top_tb.sv
